[design/tdrp_pkg.sv]
// ----------------------------------------------------------------------------
// tdrp_pkg
// Shared types, widths and codes of the transmit descriptor ring producer.
// ----------------------------------------------------------------------------
package tdrp_pkg;

  // Ring depth default
  localparam int RING_SLOTS_DEF = 1024;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int LEN_W    = 16;
  localparam int SLOT_W   = 10;
  localparam int STAT_W   = 2;
  localparam int ERR_W    = 2;
  localparam int FS_W     = 16;
  localparam int OFF_W    = 8;
  localparam int FIU_W    = 11;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 27;
  localparam int BYTES_W  = 26;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;
  localparam int WORD_W   = LEN_W + STAT_W;

  // Stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_RES_W  = 1 + ERR_W + SLOT_W + 1 + CNT_W + BYTES_W;

  // Register reset values
  localparam logic [FS_W-1:0]  FRAME_SIZE_RST  = 16'd2048;
  localparam logic [OFF_W-1:0] PAYLOAD_OFF_RST = 8'd32;
  localparam logic [FIU_W-1:0] FRAMES_USE_RST  = 11'd1024;

  // Saturation limit of the byte count output
  localparam logic [SUM_W-1:0] BYTES_MAX = SUM_W'({BYTES_W{1'b1}});

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_FRAME_SIZE  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_PAYLOAD_OFF = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_FRAMES_USE  = 2'd2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Slot status codes
  localparam logic [STAT_W-1:0] SLOT_AVAILABLE = 2'd0;
  localparam logic [STAT_W-1:0] SLOT_SEND_REQ  = 2'd1;
  localparam logic [STAT_W-1:0] SLOT_SENDING   = 2'd2;
  localparam logic [STAT_W-1:0] SLOT_WRONG_FMT = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

  // Control group from the sweep unit
  typedef struct packed {
    logic busy;
    logic wr;
    logic rd;
    logic load;
  } sweep_ctl_t;

  // A slot counts toward the pending totals
  function automatic logic is_pending(input logic [STAT_W-1:0] st);
    is_pending = (st == SLOT_SEND_REQ) || (st == SLOT_SENDING);
  endfunction

endpackage

[design/tdrp_ram.sv]
// ----------------------------------------------------------------------------
// tdrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdrp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tdrp_sweep.sv]
// ----------------------------------------------------------------------------
// tdrp_sweep
// Clears every slot status after reset and recounts the pending totals over
// the slots in use after the frames-in-use register is written.
// ----------------------------------------------------------------------------
module tdrp_sweep import tdrp_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEF,
  parameter int N_WIDTH    = FIU_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fiu_wr,
  input  logic [N_WIDTH-1:0]            n_eff,
  input  logic [WORD_W-1:0]             rdata,
  output sweep_ctl_t                    ctl,
  output logic [$clog2(RING_SLOTS)-1:0] addr,
  output logic [CNT_W-1:0]              cnt,
  output logic [SUM_W-1:0]              sum
);

  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_SLOTS - 1);

  localparam logic [1:0] SW_IDLE  = 2'd0;
  localparam logic [1:0] SW_CLEAR = 2'd1;
  localparam logic [1:0] SW_COUNT = 2'd2;
  localparam logic [1:0] SW_DRAIN = 2'd3;

  logic [1:0]       state;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_d;
  logic             rd_d;
  logic             hit;
  logic             load_q;

  // Entry returned this cycle lies in the ring and is pending
  assign hit = rd_d && (N_WIDTH'(ptr_d) < n_eff) && is_pending(rdata[STAT_W-1:0]);

  // Walk the memory one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SW_CLEAR;
      ptr    <= '0;
      rd_d   <= 1'b0;
      load_q <= 1'b0;
      cnt    <= '0;
      sum    <= '0;
    end else begin
      rd_d   <= (state == SW_COUNT) && !fiu_wr;
      load_q <= (state == SW_DRAIN) && !fiu_wr;
      ptr_d  <= ptr;
      unique case (state)
        SW_CLEAR: begin
          ptr <= ptr + IDX_W'(1);
          if (ptr == LAST) begin
            state <= SW_IDLE;
            ptr   <= '0;
          end
        end
        SW_COUNT: begin
          if (fiu_wr) begin
            ptr <= '0;
            cnt <= '0;
            sum <= '0;
          end else begin
            ptr <= ptr + IDX_W'(1);
            if (ptr == LAST) begin
              state <= SW_DRAIN;
              ptr   <= '0;
            end
            if (hit) begin
              cnt <= cnt + CNT_W'(1);
              sum <= sum + SUM_W'(rdata[WORD_W-1:STAT_W]);
            end
          end
        end
        SW_DRAIN: begin
          if (fiu_wr) begin
            state <= SW_COUNT;
            ptr   <= '0;
            cnt   <= '0;
            sum   <= '0;
          end else begin
            state <= SW_IDLE;
            if (hit) begin
              cnt <= cnt + CNT_W'(1);
              sum <= sum + SUM_W'(rdata[WORD_W-1:STAT_W]);
            end
          end
        end
        default: begin
          if (fiu_wr) begin
            state <= SW_COUNT;
            ptr   <= '0;
            cnt   <= '0;
            sum   <= '0;
          end
        end
      endcase
    end
  end

  // Memory access and load strobe; load once the last entry has been added
  assign addr     = ptr;
  assign ctl.busy = (state != SW_IDLE) || load_q;
  assign ctl.wr   = (state == SW_CLEAR);
  assign ctl.rd   = (state == SW_COUNT);
  assign ctl.load = load_q;

endmodule

[design/tx_descriptor_ring_producer.sv]
// ----------------------------------------------------------------------------
// tx_descriptor_ring_producer
// Producer side of an in-order transmit frame ring with per-slot ownership.
// ----------------------------------------------------------------------------
// Each request is handled in two steps: the slot word (status and stored
// length) is read from the slot memory, then it is modified, written back
// and the result registered once the output register is empty or being
// drained; the next request is taken after that. Pending frame and byte
// totals are kept as running counters next to the memory. After reset the
// block clears all RING_SLOTS slot statuses, one per cycle, before taking the
// first request. A write to frames_in_use starts a recount over the slot
// memory that holds off requests until it has loaded the new totals.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_producer import tdrp_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: pkt_length[15:0], report_slot[25:16], report_status[27:26], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [REQ_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: accepted[0], error_code[2:1], slot_used[12:3], reclaimed[13],
  //        pending_frames[24:14], pending_bytes[50:25], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam int NW    = $clog2(RING_SLOTS + 1);
  localparam int CW    = (NW > FIU_W) ? NW : FIU_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Configuration registers
  logic [FS_W-1:0]  frame_bytes;
  logic [OFF_W-1:0] payload_offset;
  logic [FIU_W-1:0] frames_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes    <= FRAME_SIZE_RST;
      payload_offset <= PAYLOAD_OFF_RST;
      frames_in_use  <= FRAMES_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_SIZE:  frame_bytes    <= cfg_wdata;
        REG_PAYLOAD_OFF: payload_offset <= cfg_wdata[OFF_W-1:0];
        REG_FRAMES_USE:  frames_in_use  <= cfg_wdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective ring size: zero acts as one, clamp at the memory depth
  logic [CW-1:0] fiu_ext;
  logic [CW-1:0] n_eff;

  assign fiu_ext = CW'(frames_in_use);
  assign n_eff   = (fiu_ext == '0) ? CW'(1) :
                   (fiu_ext > CW'(RING_SLOTS)) ? CW'(RING_SLOTS) : fiu_ext;

  // Request fields
  logic [LEN_W-1:0]  in_len;
  logic [SLOT_W-1:0] in_rslot;
  logic [STAT_W-1:0] in_rstat;
  logic              in_acc;

  assign in_len   = s_axis_tdata[LEN_W-1:0];
  assign in_rslot = s_axis_tdata[LEN_W+SLOT_W-1:LEN_W];
  assign in_rstat = s_axis_tdata[LEN_W+SLOT_W+STAT_W-1:LEN_W+SLOT_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Payload limit and slot selection at accept
  logic [LEN_W-1:0] limit;
  logic             too_long;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] put_idx;
  logic [IDX_W-1:0] rd_addr;

  assign limit    = (frame_bytes >= FS_W'(payload_offset)) ?
                    frame_bytes - FS_W'(payload_offset) : '0;
  assign too_long = (in_len > limit);
  assign put_idx  = (CW'(write_index) < n_eff) ? write_index : '0;
  assign rd_addr  = (s_axis_tuser == REQ_PUT) ? put_idx : IDX_W'(in_rslot);

  // Sweep unit
  sweep_ctl_t        sw_ctl;
  logic [IDX_W-1:0]  sw_addr;
  logic [CNT_W-1:0]  sw_cnt;
  logic [SUM_W-1:0]  sw_sum;
  logic [WORD_W-1:0] ram_rdata;

  tdrp_sweep #(
    .RING_SLOTS (RING_SLOTS),
    .N_WIDTH    (CW)
  ) u_sweep (
    .clk    (clk),
    .rst    (rst),
    .fiu_wr (cfg_we && (cfg_addr == REG_FRAMES_USE)),
    .n_eff  (n_eff),
    .rdata  (ram_rdata),
    .ctl    (sw_ctl),
    .addr   (sw_addr),
    .cnt    (sw_cnt),
    .sum    (sw_sum)
  );

  // Request pipeline registers
  logic              state;
  logic [REQ_W-1:0]  req_q;
  logic [LEN_W-1:0]  len_q;
  logic [STAT_W-1:0] rstat_q;
  logic [IDX_W-1:0]  addr_q;
  logic              too_long_q;
  logic              slot_ok_q;

  // Modify stage
  logic [STAT_W-1:0] old_st;
  logic [LEN_W-1:0]  old_len;
  logic              commit;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [CNT_W-1:0]  pend_cnt;
  logic [SUM_W-1:0]  pend_sum;
  logic [CNT_W-1:0]  pend_cnt_next;
  logic [SUM_W-1:0]  pend_sum_next;
  logic [IDX_W-1:0]  write_index_next;
  logic              r_acc;
  logic [ERR_W-1:0]  r_err;
  logic [SLOT_W-1:0] r_slot;
  logic              r_recl;
  logic              out_valid;
  logic [OUT_RES_W-1:0] out_res;
  logic [SUM_W-1:0]  bytes_sat;

  assign old_st  = ram_rdata[STAT_W-1:0];
  assign old_len = ram_rdata[WORD_W-1:STAT_W];
  assign commit  = (state == S_EXEC) && (!out_valid || m_axis_tready);

  // Apply the request to the slot word and the running totals
  always_comb begin
    mem_we           = 1'b0;
    mem_wdata        = ram_rdata;
    pend_cnt_next    = pend_cnt;
    pend_sum_next    = pend_sum;
    write_index_next = write_index;
    r_acc            = 1'b0;
    r_err            = ERR_NONE;
    r_slot           = '0;
    r_recl           = 1'b0;
    case (req_q)
      REQ_PUT: begin
        if (too_long_q) begin
          r_err = ERR_TOO_LONG;
        end else if (old_st == SLOT_AVAILABLE || old_st == SLOT_WRONG_FMT) begin
          mem_we        = 1'b1;
          mem_wdata     = {len_q, SLOT_SEND_REQ};
          pend_cnt_next = pend_cnt + CNT_W'(1);
          pend_sum_next = pend_sum + SUM_W'(len_q);
          r_acc         = 1'b1;
          r_slot        = SLOT_W'(addr_q);
          r_recl        = (old_st == SLOT_WRONG_FMT);
          if ((CW'(addr_q) + CW'(1)) >= n_eff) begin
            write_index_next = '0;
          end else begin
            write_index_next = addr_q + IDX_W'(1);
          end
        end else begin
          r_err            = ERR_FULL;
          write_index_next = addr_q;
        end
      end
      REQ_REPORT: begin
        if (slot_ok_q) begin
          mem_we    = 1'b1;
          mem_wdata = {old_len, rstat_q};
          if (is_pending(old_st) && !is_pending(rstat_q)) begin
            pend_cnt_next = pend_cnt - CNT_W'(1);
            pend_sum_next = pend_sum - SUM_W'(old_len);
          end else if (!is_pending(old_st) && is_pending(rstat_q)) begin
            pend_cnt_next = pend_cnt + CNT_W'(1);
            pend_sum_next = pend_sum + SUM_W'(old_len);
          end
        end
      end
      default: ;
    endcase
  end

  assign bytes_sat = (pend_sum_next > BYTES_MAX) ? BYTES_MAX : pend_sum_next;

  // Sequence read then modify-write
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      pend_cnt    <= '0;
      pend_sum    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state       <= S_IDLE;
            write_index <= write_index_next;
            pend_cnt    <= pend_cnt_next;
            pend_sum    <= pend_sum_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (sw_ctl.load) begin
        pend_cnt <= sw_cnt;
        pend_sum <= sw_sum;
      end
    end
  end

  // Capture the request at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_q      <= s_axis_tuser;
      len_q      <= in_len;
      rstat_q    <= in_rstat;
      addr_q     <= rd_addr;
      too_long_q <= too_long;
      slot_ok_q  <= (CW'(in_rslot) < n_eff);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res <= {bytes_sat[BYTES_W-1:0], pend_cnt_next, r_recl, r_slot, r_err, r_acc};
    end
  end

  // Slot memory: sweep owns it while busy
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;

  assign ram_we    = sw_ctl.busy ? sw_ctl.wr : (commit && mem_we);
  assign ram_waddr = sw_ctl.busy ? sw_addr : addr_q;
  assign ram_wdata = sw_ctl.busy ? '0 : mem_wdata;
  assign ram_re    = sw_ctl.busy ? sw_ctl.rd : in_acc;
  assign ram_raddr = sw_ctl.busy ? sw_addr : rd_addr;

  tdrp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Port drive
  assign s_axis_tready = (state == S_IDLE) && !sw_ctl.busy;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_RES_W)'(0), out_res};

endmodule

[dv/tdrp_ring_checker.sv]
// ----------------------------------------------------------------------------
// tdrp_ring_checker
// Watches the request, result and configuration channels of the transmit
// descriptor ring producer. It keeps its own copy of the slot ring and
// configuration, works out the result of every accepted request, and compares
// each accepted result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module tdrp_ring_checker import tdrp_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [REQ_W-1:0]      s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count,
  output int                    outstanding,
  // Slots that have taken a length from an accepted put
  output logic [RING_SLOTS-1:0] len_known
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FRAMES_SAT = (longint'(1) << CNT_W) - 1;
  localparam longint BYTES_SAT  = (longint'(1) << BYTES_W) - 1;

  // Result item, accepted in the lowest bit as on the result stream
  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   frames;
    logic               reclaimed;
    logic [SLOT_W-1:0]  slot;
    logic [ERR_W-1:0]   err;
    logic               accepted;
  } ring_result_t;

  ring_result_t      result_q[$];
  logic [STAT_W-1:0] ring_status [RING_SLOTS];
  logic [LEN_W-1:0]  ring_len [RING_SLOTS];
  int                wr_ptr;
  logic [FS_W-1:0]   frame_bytes;
  logic [OFF_W-1:0]  payload_off;
  logic [FIU_W-1:0]  frames_use;
  int                mismatches;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    len_known   = '0;
    mismatches  = 0;
  end

  function automatic int active_slots();
    if (frames_use == '0) return 1;
    if (int'(frames_use) > RING_SLOTS) return RING_SLOTS;
    return int'(frames_use);
  endfunction

  // Apply one request to the ring copy and return its result
  function automatic ring_result_t advance_ring(input logic [REQ_W-1:0]  req,
                                                input logic [LEN_W-1:0]  len,
                                                input logic [SLOT_W-1:0] rslot,
                                                input logic [STAT_W-1:0] rstat);
    ring_result_t      res;
    int                n;
    int                limit;
    int                idx;
    logic [STAT_W-1:0] st;
    longint            cnt;
    longint            sum;
    res = '0;
    n   = active_slots();
    case (req)
      REQ_PUT: begin
        // payload limit saturates at zero when the offset exceeds the frame
        limit = (int'(frame_bytes) >= int'(payload_off)) ?
                int'(frame_bytes) - int'(payload_off) : 0;
        if (int'(len) > limit) begin
          res.err = ERR_TOO_LONG;
        end else begin
          // a write index left beyond the ring restarts at slot zero
          idx = (wr_ptr < n) ? wr_ptr : 0;
          st  = ring_status[idx];
          if (st == SLOT_AVAILABLE || st == SLOT_WRONG_FMT) begin
            res.accepted    = 1'b1;
            res.reclaimed   = (st == SLOT_WRONG_FMT);
            res.slot        = idx[SLOT_W-1:0];
            ring_len[idx]    = len;
            ring_status[idx] = SLOT_SEND_REQ;
            wr_ptr = (idx + 1 >= n) ? 0 : idx + 1;
          end else begin
            wr_ptr  = idx;
            res.err = ERR_FULL;
          end
        end
      end
      REQ_REPORT: begin
        // drop reports beyond the ring
        if (int'(rslot) < n) ring_status[rslot] = rstat;
      end
      default: ;
    endcase
    // Total up pending slots inside the ring
    cnt = 0;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      if (ring_status[i] == SLOT_SEND_REQ || ring_status[i] == SLOT_SENDING) begin
        cnt++;
        sum += ring_len[i];
      end
    end
    res.frames = CNT_W'((cnt > FRAMES_SAT) ? FRAMES_SAT : cnt);
    res.bytes  = BYTES_W'((sum > BYTES_SAT) ? BYTES_SAT : sum);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    ring_result_t res;
    if (rst) begin
      for (int i = 0; i < RING_SLOTS; i++) begin
        ring_status[i] = SLOT_AVAILABLE;
        ring_len[i]    = '0;
      end
      wr_ptr      = 0;
      frame_bytes = FRAME_SIZE_RST;
      payload_off = PAYLOAD_OFF_RST;
      frames_use  = FRAMES_USE_RST;
      result_q.delete();
      len_known <= '0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_SIZE:  frame_bytes = cfg_wdata[FS_W-1:0];
          REG_PAYLOAD_OFF: payload_off = cfg_wdata[OFF_W-1:0];
          REG_FRAMES_USE:  frames_use  = cfg_wdata[FIU_W-1:0];
          default: ;
        endcase
      end
      // Compare a result item with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_RES_W-1:0];
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", longint'(m_axis_tdata), 0);
        end else begin
          want = result_q.pop_front();
          if (got.accepted != want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.err != want.err)
            report_mismatch("error_code", got.err, want.err);
          if (got.slot != want.slot)
            report_mismatch("slot_used", got.slot, want.slot);
          if (got.reclaimed != want.reclaimed)
            report_mismatch("reclaimed", got.reclaimed, want.reclaimed);
          if (got.frames != want.frames)
            report_mismatch("pending_frames", got.frames, want.frames);
          if (got.bytes != want.bytes)
            report_mismatch("pending_bytes", got.bytes, want.bytes);
        end
      end
      // Predict the result of a request item
      if (s_axis_tvalid && s_axis_tready) begin
        res = advance_ring(s_axis_tuser, s_axis_tdata[LEN_W-1:0],
                           s_axis_tdata[LEN_W +: SLOT_W],
                           s_axis_tdata[LEN_W+SLOT_W +: STAT_W]);
        result_q.push_back(res);
        if (res.accepted) len_known[res.slot] <= 1'b1;
      end
    end
    outstanding <= result_q.size();
    fail_count  <= mismatches;
  end

endmodule

[dv/tb_tx_descriptor_ring_producer.sv]
// ----------------------------------------------------------------------------
// tb_tx_descriptor_ring_producer
// Drives the transmit descriptor ring producer with a directed opening and
// then random put, report and query traffic over several ring settings, with
// random idling on both streams, a long result hold-off and a full drain
// pause. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tx_descriptor_ring_producer;
  import tdrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS   = RING_SLOTS_DEF;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_LEN     = 300;
  localparam int HOLD_AT      = 20;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 8;
  // Run limit: covers a clear pass, ten recounts and about 1300 items with
  // stalls several times over.
  localparam int CYCLE_LIMIT  = 200000;

  // Spare request code, handled as a query
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr      = '0;
  logic [CFG_D_W-1:0]    cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int                    fail_count;
  int                    outstanding;
  logic [RING_SLOTS-1:0] len_known;

  logic calm        = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_cycles = 0;
  int   cycles      = 0;

  // Ring setting last written, used to shape stimulus
  int cur_fs  = FRAME_SIZE_RST;
  int cur_off = PAYLOAD_OFF_RST;
  int cur_fiu = FRAMES_USE_RST;

  tx_descriptor_ring_producer #(.RING_SLOTS(RING_SLOTS)) dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  tdrp_ring_checker #(.RING_SLOTS(RING_SLOTS)) ring_chk (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count, .outstanding, .len_known
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one request item and hold it until it is taken
  task automatic send_item(input logic [REQ_W-1:0]  req,
                           input logic [LEN_W-1:0]  len,
                           input logic [SLOT_W-1:0] slot,
                           input logic [STAT_W-1:0] stat);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(IN_DATA_W-LEN_W-SLOT_W-STAT_W){1'b0}}, stat, slot, len};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic set_ring_config(input int fs, input int off, input int fiu);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FRAME_SIZE;
    cfg_wdata <= CFG_D_W'(fs);
    @(posedge clk);
    cfg_addr  <= REG_PAYLOAD_OFF;
    cfg_wdata <= CFG_D_W'(off);
    @(posedge clk);
    cfg_addr  <= REG_FRAMES_USE;
    cfg_wdata <= CFG_D_W'(fiu);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_fs  = fs;
    cur_off = off;
    cur_fiu = fiu;
  endtask

  // Pick a random request shaped by the current ring setting
  task automatic pick_item(output logic [REQ_W-1:0]  req,
                           output logic [LEN_W-1:0]  len,
                           output logic [SLOT_W-1:0] slot,
                           output logic [STAT_W-1:0] stat);
    int n;
    int limit;
    int r;
    int k;
    n     = (cur_fiu == 0) ? 1 : (cur_fiu > RING_SLOTS) ? RING_SLOTS : cur_fiu;
    limit = (cur_fs >= cur_off) ? cur_fs - cur_off : 0;
    r     = $urandom_range(99);
    // fields the request does not use carry noise
    len   = LEN_W'($urandom);
    slot  = SLOT_W'($urandom);
    stat  = STAT_W'($urandom);
    if (r < 45) begin
      req = REQ_PUT;
      k   = $urandom_range(9);
      if (k == 0) len = '0;
      else if (k == 1) len = LEN_W'(limit);
      else if (k <= 3 && limit < 65535) len = LEN_W'($urandom_range(65535, limit + 1));
      else len = LEN_W'($urandom_range(limit, 0));
    end else if (r < 85) begin
      req = REQ_REPORT;
      if (n < RING_SLOTS && $urandom_range(9) == 0)
        slot = SLOT_W'($urandom_range(RING_SLOTS - 1, n));
      else slot = SLOT_W'($urandom_range(n - 1, 0));
      k = $urandom_range(99);
      stat = (k < 35) ? SLOT_AVAILABLE : (k < 60) ? SLOT_WRONG_FMT :
             (k < 80) ? SLOT_SEND_REQ : SLOT_SENDING;
      // never make a slot pending before a put has stored its length
      if ((stat == SLOT_SEND_REQ || stat == SLOT_SENDING) && !len_known[slot])
        stat = SLOT_WRONG_FMT;
    end else begin
      req = ($urandom_range(3) == 0) ? REQ_SPARE : REQ_QUERY;
    end
  endtask

  task automatic run_random(input int count, input bit with_hold, input bit with_pause);
    logic [REQ_W-1:0]  req;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] stat;
    for (int i = 0; i < count; i++) begin
      if (with_pause && i == count / 2) drain_results();
      if (with_hold && i == HOLD_AT) hold_req <= 1'b1;
      pick_item(req, len, slot, stat);
      send_item(req, len, slot, stat);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Queries, payload limit edges and reports at the reset setting
    send_item(REQ_QUERY, '0, '0, SLOT_AVAILABLE);
    send_item(REQ_SPARE, '1, '1, SLOT_WRONG_FMT);
    send_item(REQ_PUT, 16'd0, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd2016, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd2017, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'hFFFF, '0, SLOT_AVAILABLE);
    send_item(REQ_REPORT, '0, 10'd0, SLOT_SENDING);
    send_item(REQ_REPORT, '0, 10'd1, SLOT_WRONG_FMT);
    send_item(REQ_REPORT, '0, 10'd1023, SLOT_AVAILABLE);
    send_item(REQ_REPORT, '0, 10'd0, SLOT_AVAILABLE);

    // Two-slot ring: stale index, reclaim, ring full, report beyond ring
    set_ring_config(2048, 32, 2);
    send_item(REQ_PUT, 16'd100, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd200, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd300, '0, SLOT_AVAILABLE);
    send_item(REQ_REPORT, '0, 10'd1023, SLOT_WRONG_FMT);
    send_item(REQ_REPORT, '0, 10'd0, SLOT_SENDING);
    send_item(REQ_QUERY, '0, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd350, '0, SLOT_AVAILABLE);
    send_item(REQ_REPORT, '0, 10'd0, SLOT_WRONG_FMT);
    send_item(REQ_PUT, 16'd400, '0, SLOT_AVAILABLE);

    // Offset above frame size: only empty packets fit
    set_ring_config(100, 200, 2);
    send_item(REQ_REPORT, '0, 10'd1, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd1, '0, SLOT_AVAILABLE);
    send_item(REQ_PUT, 16'd0, '0, SLOT_AVAILABLE);
    send_item(REQ_QUERY, '0, '0, SLOT_AVAILABLE);

    // Random traffic over a range of ring settings
    set_ring_config(65535, 0, 16);
    run_random(160, 1'b0, 1'b1);
    set_ring_config(1500, 255, 0);
    run_random(150, 1'b0, 1'b0);
    set_ring_config(0, 255, 1);
    run_random(100, 1'b0, 1'b0);
    calm <= 1'b1;
    set_ring_config(65535, 255, 2047);
    run_random(200, 1'b0, 1'b0);
    calm <= 1'b0;
    set_ring_config(64, 8, 4);
    run_random(160, 1'b0, 1'b0);
    set_ring_config(4096, 16, 1025);
    run_random(200, 1'b1, 1'b0);
    set_ring_config($urandom_range(65535, 0), $urandom_range(255, 0), $urandom_range(32, 1));
    run_random(160, 1'b0, 1'b0);
    set_ring_config($urandom_range(65535, 0), $urandom_range(255, 0), $urandom_range(2047, 0));
    run_random(160, 1'b0, 1'b0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/tdrp_pkg.sv
design/tdrp_ram.sv
design/tdrp_sweep.sv
design/tx_descriptor_ring_producer.sv
dv/tdrp_ring_checker.sv
dv/tb_tx_descriptor_ring_producer.sv
